@@ hdl/lslf_pkg.sv @@
// ============================================================================
// lslf_pkg : shared types and constants for the least-squares line fit
// Sizes of the running sums, the multiply and divide units, the transaction
// structs, controller state and the command/status bundles.
// ============================================================================
`timescale 1ns / 1ps

package lslf_pkg;

   localparam int MAX_POINTS    = 4096;
   localparam int FRACTION_BITS = 16;

   // transaction field widths
   localparam int X_W   = 16;
   localparam int Y_W   = 16;
   localparam int OUT_W = 48;
   localparam int PTS_W = 13;

   // running sums
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int SX_W  = X_W + CNT_W;
   localparam int SY_W  = Y_W + CNT_W;
   localparam int SXX_W = 2 * X_W + CNT_W;
   localparam int SXY_W = X_W + Y_W + CNT_W;

   // multiplier: signed operands wide enough for any sum or the count
   localparam int OP_W   = ((SXX_W > SXY_W) ? SXX_W : SXY_W) + 1;
   localparam int PROD_W = 2 * OP_W;
   localparam int MCNT_W = $clog2(OP_W + 1);

   // divider: denominator n*Sxx - Sx*Sx, numerators up to Sy*Sxx - Sx*Sxy
   localparam int DEN_W  = CNT_W + SXX_W;
   localparam int NUM_W  = SY_W + SXX_W + 1;
   localparam int DVD_W  = NUM_W + FRACTION_BITS;
   localparam int DCNT_W = $clog2(DVD_W + 1);

   localparam logic [OUT_W-1:0] POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

   typedef struct packed {
      logic        [X_W-1:0] x_value;
      logic signed [Y_W-1:0] y_value;
      logic                  is_last;
   } lslf_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] fit_slope;
      logic signed [OUT_W-1:0] fit_intercept;
      logic        [PTS_W-1:0] points_used;
      logic                    degenerate;
      logic                    overflowed;
   } lslf_rsp_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_CHECK,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EMIT
   } lslf_state_type;

   // product sequence; pairs are combined as first minus second
   typedef enum logic [2:0] {
      MUL_N_SXX,
      MUL_SX_SX,
      MUL_N_SXY,
      MUL_SX_SY,
      MUL_SY_SXX,
      MUL_SX_SXY
   } lslf_mul_type;

   typedef enum logic {
      DIV_SLOPE,
      DIV_INTERCEPT
   } lslf_div_type;

   typedef struct packed {
      logic         accum;
      logic         mul_start;
      lslf_mul_type mul_op;
      logic         div_start;
      lslf_div_type div_sel;
      logic         emit;
   } lslf_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic den_bad;
      logic rsp_free;
   } lslf_status_type;

endpackage

@@ hdl/lslf_mul.sv @@
// ============================================================================
// lslf_mul : iterative signed multiplier
// Shift-and-add on magnitudes, one multiplier bit per cycle, sign applied
// at the end. done pulses for one cycle with product valid.
// ============================================================================
`timescale 1ns / 1ps

module lslf_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [lslf_pkg::OP_W-1:0]    op_a,
   input  logic signed [lslf_pkg::OP_W-1:0]    op_b,
   output logic                                done,
   output logic signed [lslf_pkg::PROD_W-1:0]  product
);
   import lslf_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [MCNT_W-1:0]        cnt_ff, cnt_in;
   logic [PROD_W-1:0]        mcand_ff, mcand_in;
   logic [OP_W-1:0]          mplier_ff, mplier_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic                     neg_ff, neg_in;
   logic signed [PROD_W-1:0] product_ff, product_in;
   logic [OP_W-1:0]          mag_a, mag_b;

   assign mag_a = op_a[OP_W-1] ? OP_W'(-op_a) : OP_W'(op_a);
   assign mag_b = op_b[OP_W-1] ? OP_W'(-op_b) : OP_W'(op_b);

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      mcand_in   = mcand_ff;
      mplier_in  = mplier_ff;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      product_in = product_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mcand_in  = PROD_W'(mag_a);
         mplier_in = mag_b;
         acc_in    = '0;
         neg_in    = op_a[OP_W-1] ^ op_b[OP_W-1];
      end else if (busy_ff) begin
         if (cnt_ff == MCNT_W'(OP_W)) begin
            busy_in    = 1'b0;
            done_in    = 1'b1;
            product_in = neg_ff ? -acc_ff : acc_ff;
         end else begin
            acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      acc_ff     <= acc_in;
      neg_ff     <= neg_in;
      product_ff <= product_in;
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

@@ hdl/lslf_div.sv @@
// ============================================================================
// lslf_div : iterative scaled divider
// Restoring division of |num| * 2^FRACTION_BITS by a positive denominator,
// one quotient bit per cycle; sign restored and 48-bit saturation at the end.
// ============================================================================
`timescale 1ns / 1ps

module lslf_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [lslf_pkg::NUM_W-1:0]  num,
   input  logic        [lslf_pkg::DEN_W-1:0]  den,
   output logic                               done,
   output logic signed [lslf_pkg::OUT_W-1:0]  quotient
);
   import lslf_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DCNT_W-1:0]       cnt_ff, cnt_in;
   logic [DVD_W-1:0]        dvd_ff, dvd_in;
   logic [DVD_W-1:0]        quo_ff, quo_in;
   logic [DEN_W-1:0]        rem_ff, rem_in;
   logic [DEN_W-1:0]        dsr_ff, dsr_in;
   logic                    neg_ff, neg_in;
   logic signed [OUT_W-1:0] result_ff, result_in;
   logic [NUM_W-1:0]        mag;
   logic [DEN_W:0]          rem_sh;
   logic                    fits;

   assign mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
   assign fits   = rem_sh >= {1'b0, dsr_ff};

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      neg_in    = neg_ff;
      result_in = result_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = DVD_W'(mag) << FRACTION_BITS;
         quo_in  = '0;
         rem_in  = '0;
         dsr_in  = den;
         neg_in  = num[NUM_W-1];
      end else if (busy_ff) begin
         if (cnt_ff == DCNT_W'(DVD_W)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               result_in = (quo_ff > DVD_W'(NEG_LIMIT)) ? NEG_LIMIT : -quo_ff[OUT_W-1:0];
            end else begin
               result_in = (quo_ff > DVD_W'(POS_LIMIT)) ? POS_LIMIT : quo_ff[OUT_W-1:0];
            end
         end else begin
            // remainder stays below the divisor, so DEN_W bits hold it
            rem_in = fits ? DEN_W'(rem_sh - {1'b0, dsr_ff}) : rem_sh[DEN_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], fits};
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dsr_ff    <= dsr_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign done     = done_ff;
   assign quotient = result_ff;

endmodule

@@ hdl/lslf_dp.sv @@
// ============================================================================
// lslf_dp : line fit datapath
// Point accumulators, shared multiplier and divider, denominator and
// numerator registers, and the result register of the rsp channel.
// ============================================================================
`timescale 1ns / 1ps

module lslf_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  lslf_pkg::lslf_cmd_type    cmd,
   output lslf_pkg::lslf_status_type status,
   input  lslf_pkg::lslf_req_type    req_data,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output lslf_pkg::lslf_rsp_type    rsp_data
);
   import lslf_pkg::*;

   // running sums
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [SX_W-1:0]         sx_ff, sx_in;
   logic signed [SY_W-1:0]  sy_ff, sy_in;
   logic [SXX_W-1:0]        sxx_ff, sxx_in;
   logic signed [SXY_W-1:0] sxy_ff, sxy_in;
   logic                    dropped_ff, dropped_in;

   // fit registers
   logic signed [PROD_W-1:0] first_ff, first_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic                     den_bad_ff, den_bad_in;
   logic signed [NUM_W-1:0]  ns_ff, ns_in;
   logic signed [NUM_W-1:0]  ni_ff, ni_in;
   logic signed [OUT_W-1:0]  slope_ff, slope_in;
   logic signed [OUT_W-1:0]  icpt_ff, icpt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   lslf_rsp_type             rsp_data_ff, rsp_data_in;

   logic [2*X_W-1:0]         x_sq;
   logic signed [X_W+Y_W:0]  xy;
   logic signed [OP_W-1:0]   mul_a, mul_b;
   logic                     mul_done;
   logic signed [PROD_W-1:0] mul_product;
   logic signed [PROD_W-1:0] diff;
   logic signed [NUM_W-1:0]  div_num;
   logic                     div_done;
   logic signed [OUT_W-1:0]  div_quotient;

   assign x_sq = req_data.x_value * req_data.x_value;
   assign xy   = $signed({1'b0, req_data.x_value}) * req_data.y_value;
   assign diff = first_ff - mul_product;

   always_comb begin
      case (cmd.mul_op)
         MUL_N_SXX: begin
            mul_a = OP_W'(count_ff);
            mul_b = OP_W'(sxx_ff);
         end
         MUL_SX_SX: begin
            mul_a = OP_W'(sx_ff);
            mul_b = OP_W'(sx_ff);
         end
         MUL_N_SXY: begin
            mul_a = OP_W'(count_ff);
            mul_b = OP_W'(sxy_ff);
         end
         MUL_SX_SY: begin
            mul_a = OP_W'(sx_ff);
            mul_b = OP_W'(sy_ff);
         end
         MUL_SY_SXX: begin
            mul_a = OP_W'(sy_ff);
            mul_b = OP_W'(sxx_ff);
         end
         MUL_SX_SXY: begin
            mul_a = OP_W'(sx_ff);
            mul_b = OP_W'(sxy_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign div_num = (cmd.div_sel == DIV_SLOPE) ? ns_ff : ni_ff;

   lslf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   lslf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (div_num),
      .den      (den_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      count_in     = count_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sxx_in       = sxx_ff;
      sxy_in       = sxy_ff;
      dropped_in   = dropped_ff;
      first_in     = first_ff;
      den_in       = den_ff;
      den_bad_in   = den_bad_ff;
      ns_in        = ns_ff;
      ni_in        = ni_ff;
      slope_in     = slope_ff;
      icpt_in      = icpt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.accum) begin
         if (count_ff < CNT_W'(MAX_POINTS)) begin
            count_in = count_ff + 1'b1;
            sx_in    = sx_ff + SX_W'(req_data.x_value);
            sy_in    = sy_ff + SY_W'(req_data.y_value);
            sxx_in   = sxx_ff + SXX_W'(x_sq);
            sxy_in   = sxy_ff + SXY_W'(xy);
         end else begin
            dropped_in = 1'b1;
         end
      end

      if (mul_done) begin
         case (cmd.mul_op)
            MUL_SX_SX: begin
               den_in     = diff[DEN_W-1:0];
               den_bad_in = diff[PROD_W-1] || (diff == '0);
            end
            MUL_SX_SY:  ns_in = diff[NUM_W-1:0];
            MUL_SX_SXY: ni_in = diff[NUM_W-1:0];
            default:    first_in = mul_product;
         endcase
      end

      if (div_done) begin
         if (cmd.div_sel == DIV_SLOPE) begin
            slope_in = div_quotient;
         end else begin
            icpt_in = div_quotient;
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.fit_slope     = den_bad_ff ? '0 : slope_ff;
         rsp_data_in.fit_intercept = den_bad_ff ? '0 : icpt_ff;
         rsp_data_in.points_used   = PTS_W'(count_ff);
         rsp_data_in.degenerate    = den_bad_ff;
         rsp_data_in.overflowed    = dropped_ff;
         count_in   = '0;
         sx_in      = '0;
         sy_in      = '0;
         sxx_in     = '0;
         sxy_in     = '0;
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sxx_ff       <= '0;
         sxy_ff       <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sxx_ff       <= sxx_in;
         sxy_ff       <= sxy_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff    <= first_in;
      den_ff      <= den_in;
      den_bad_ff  <= den_bad_in;
      ns_ff       <= ns_in;
      ni_ff       <= ni_in;
      slope_ff    <= slope_in;
      icpt_ff     <= icpt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.mul_done = mul_done;
   assign status.div_done = div_done;
   assign status.den_bad  = den_bad_ff;
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count above capacity");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (count_ff == '0) && !dropped_ff && (sx_ff == '0) && (sxx_ff == '0))
      else $error("sums not cleared after fit");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.emit))
      else $error("result raised without emit");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.degenerate |->
         (rsp_data_ff.fit_slope == '0) && (rsp_data_ff.fit_intercept == '0))
      else $error("degenerate fit with nonzero line");

endmodule

@@ hdl/lslf_ctrl.sv @@
// ============================================================================
// lslf_ctrl : line fit sequencer
// Takes points until one is marked last, then walks the six products,
// the degenerate check, the two divisions unless degenerate, and the result write.
// ============================================================================
`timescale 1ns / 1ps

module lslf_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_last,
   input  lslf_pkg::lslf_status_type status,
   output lslf_pkg::lslf_cmd_type    cmd,
   output logic                      req_ready
);
   import lslf_pkg::*;

   lslf_state_type state_ff, state_in;
   lslf_mul_type   mul_op_ff, mul_op_in;
   lslf_div_type   div_sel_ff, div_sel_in;
   lslf_mul_type   mul_op_next;

   always_comb begin
      case (mul_op_ff)
         MUL_N_SXX:  mul_op_next = MUL_SX_SX;
         MUL_SX_SX:  mul_op_next = MUL_N_SXY;
         MUL_N_SXY:  mul_op_next = MUL_SX_SY;
         MUL_SX_SY:  mul_op_next = MUL_SY_SXX;
         MUL_SY_SXX: mul_op_next = MUL_SX_SXY;
         default:    mul_op_next = MUL_N_SXX;
      endcase
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      mul_op_in  = mul_op_ff;
      div_sel_in = div_sel_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (req_valid && req_last) begin
               state_in = ST_MUL_GO;
            end
         end
         ST_MUL_GO: state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (status.mul_done) begin
               if (mul_op_ff == MUL_SX_SXY) begin
                  state_in = ST_CHECK;
               end else begin
                  mul_op_in = mul_op_next;
                  state_in  = ST_MUL_GO;
               end
            end
         end
         ST_CHECK: state_in = status.den_bad ? ST_EMIT : ST_DIV_GO;
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               if (div_sel_ff == DIV_INTERCEPT) begin
                  state_in = ST_EMIT;
               end else begin
                  div_sel_in = DIV_INTERCEPT;
                  state_in   = ST_DIV_GO;
               end
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               state_in   = ST_ACCUM;
               mul_op_in  = MUL_N_SXX;
               div_sel_in = DIV_SLOPE;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = (state_ff == ST_ACCUM);
      cmd.accum     = (state_ff == ST_ACCUM) && req_valid;
      cmd.mul_start = (state_ff == ST_MUL_GO);
      cmd.mul_op    = mul_op_ff;
      cmd.div_start = (state_ff == ST_DIV_GO);
      cmd.div_sel   = div_sel_ff;
      cmd.emit      = (state_ff == ST_EMIT) && status.rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_ACCUM;
         mul_op_ff  <= MUL_N_SXX;
         div_sel_ff <= DIV_SLOPE;
      end else begin
         state_ff   <= state_in;
         mul_op_ff  <= mul_op_in;
         div_sel_ff <= div_sel_in;
      end
   end

endmodule

@@ hdl/least_squares_line_fit.sv @@
// ============================================================================
// least_squares_line_fit : streaming straight-line least-squares fit
// Points (x unsigned, y signed Q16.0) enter on the req channel, one per cycle
// while the block is collecting. Each point adds into the count and the sums
// of x, y, x*x and x*y; once MAX_POINTS are held, further points are dropped
// and the overflowed flag is set for that set. The point marked is_last closes
// the set (it is accumulated first, capacity permitting) and starts the fit:
// six products on one 46x46 shift-add multiplier, a degenerate check, then,
// unless the set is degenerate, slope and intercept from one restoring
// divider, one quotient bit per cycle over the 91-bit scaled numerator.
// req_stall stays high from the last point until the result is written, and
// the sums are cleared as the result is written. Slope and intercept carry
// FRACTION_BITS fraction bits, truncate toward zero and saturate to 48 bits.
// ============================================================================
`timescale 1ns / 1ps

module least_squares_line_fit (
   input  logic                   clock,
   input  logic                   reset,
   // point transactions
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lslf_pkg::lslf_req_type req_data,
   // fit result transactions
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lslf_pkg::lslf_rsp_type rsp_data
);
   import lslf_pkg::*;

   lslf_cmd_type    cmd;
   lslf_status_type status;
   logic            req_ready;

   // Points are taken only while collecting. The result sits in its own
   // register, so a new set can start collecting while the previous fit
   // waits for the downstream side; only the next fit's write waits on it.
   assign req_stall = !req_ready;

   // Sequencer: collection, product walk, divisions, result write.
   lslf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.is_last),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   // Sums, multiplier, divider and the result register.
   lslf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ bench/least_squares_line_fit_test.sv @@
// ============================================================================
// least_squares_line_fit_test : self-checking bench for the line-fit block
// Streams point transactions into the block and checks each fit result,
// field by field, against a bit-accurate slope/intercept predictor kept in
// the bench. The run covers degenerate sets and saturation of the intercept,
// then random sets of several shapes, under shifting idle and stall patterns
// and one long result hold-off.
// ============================================================================
`timescale 1ns / 1ps

module least_squares_line_fit_test;
   import lslf_pkg::*;

   localparam int CLOCK_HALF      = 4;      // 8 ns period
   localparam int RESET_CYCLES    = 11;
   localparam int PHASE_CYCLES    = 2500;   // length of one idle pattern
   localparam int HOLD_OFF_CYCLES = 2000;   // long result back-pressure
   localparam int QUIET_LIMIT     = 12000;  // cycles without any transaction
   localparam int DRAIN_CYCLES    = 600;    // longer than one full fit
   localparam int RANDOM_POINTS   = 1800;
   localparam int MAX_PRINTED     = 100;
   // wide enough for (Sy*Sxx - Sx*Sxy) << FRACTION_BITS with margin
   localparam int WIDE_W          = 136;

   typedef logic signed [WIDE_W-1:0] wide_int;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_phase_type;

   typedef enum logic [1:0] {
      SET_SPREAD,    // x and y anywhere in range
      SET_RAMP,      // x stepping up, y near a line
      SET_SAME_X,    // every x equal: degenerate
      SET_NARROW     // x within a few units, small y
   } set_shape_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   lslf_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   lslf_rsp_type rsp_data;

   least_squares_line_fit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   lslf_req_type point_queue[$];   // points waiting to be sent
   lslf_rsp_type fit_queue[$];     // fits predicted, not yet seen

   // predictor copy of the running sums
   int      held_count   = 0;
   longint  sum_x        = 0;
   longint  sum_y        = 0;
   longint  sum_xx       = 0;
   longint  sum_xy       = 0;
   bit      dropped      = 1'b0;

   int      mismatch_count = 0;
   int      fits_seen      = 0;
   int      cycle_count    = 0;
   int      quiet_cycles   = 0;
   logic    hold_off       = 1'b0;

   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Mismatch reporting: one line each, printing capped, counting not.
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what);
      if (mismatch_count < MAX_PRINTED)
         $display("tb: mismatch at %0t ns: %s", $realtime, what);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Idle pattern rotates every PHASE_CYCLES: none, sender gaps,
   // receiver stalls, both lightly. Gaps land on every stage of a fit.
   // ------------------------------------------------------------------------
   function automatic idle_phase_type current_phase();
      return idle_phase_type'((cycle_count / PHASE_CYCLES) % 4);
   endfunction

   function automatic bit sender_rests();
      case (current_phase())
         IDLE_SENDER: return $urandom_range(99) < 68;
         IDLE_BOTH:   return $urandom_range(99) < 13;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_rests();
      case (current_phase())
         IDLE_RECEIVER: return $urandom_range(99) < 68;
         IDLE_BOTH:     return $urandom_range(99) < 13;
         default:       return 1'b0;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // num * 2^FRACTION_BITS / den for den > 0, truncated toward zero,
   // clamped to the 48-bit signed range.
   // ------------------------------------------------------------------------
   function automatic logic [OUT_W-1:0] scaled_ratio(wide_int num, wide_int den);
      bit      neg;
      wide_int mag;
      wide_int quo;
      wide_int lim;
      lim = 1;
      lim = lim <<< (OUT_W - 1);
      neg = num < 0;
      mag = neg ? -num : num;
      quo = (mag <<< FRACTION_BITS) / den;
      if (neg) begin
         if (quo > lim)
            return NEG_LIMIT;
         quo = -quo;
         return quo[OUT_W-1:0];
      end else begin
         if (quo > lim - 1)
            return POS_LIMIT;
         return quo[OUT_W-1:0];
      end
   endfunction

   // ------------------------------------------------------------------------
   // Predictor: fold one accepted point into the sums; on the last point of a
   // set, work out the fit, queue it and clear the sums.
   // ------------------------------------------------------------------------
   function automatic void accumulate_point(lslf_req_type pt);
      longint       px;
      longint       py;
      wide_int      n_w, sx_w, sy_w, sxx_w, sxy_w, den;
      lslf_rsp_type fit;
      px = pt.x_value;
      py = $signed(pt.y_value);
      // past capacity the point is dropped but still may close the set
      if (held_count < MAX_POINTS) begin
         held_count++;
         sum_x  += px;
         sum_y  += py;
         sum_xx += px * px;
         sum_xy += px * py;
      end else begin
         dropped = 1'b1;
      end
      if (pt.is_last) begin
         n_w   = held_count;
         sx_w  = sum_x;
         sy_w  = sum_y;
         sxx_w = sum_xx;
         sxy_w = sum_xy;
         den   = n_w * sxx_w - sx_w * sx_w;
         fit.points_used = PTS_W'(held_count);
         fit.overflowed  = dropped;
         // one point or all x equal leaves nothing to divide by
         if (den <= 0) begin
            fit.fit_slope     = '0;
            fit.fit_intercept = '0;
            fit.degenerate    = 1'b1;
         end else begin
            // intercept from the exact sums, not from the rounded slope
            fit.fit_slope     = scaled_ratio(n_w * sxy_w - sx_w * sy_w, den);
            fit.fit_intercept = scaled_ratio(sy_w * sxx_w - sx_w * sxy_w, den);
            fit.degenerate    = 1'b0;
         end
         fit_queue.insert(fit_queue.size(), fit);
         held_count = 0;
         sum_x      = 0;
         sum_y      = 0;
         sum_xx     = 0;
         sum_xy     = 0;
         dropped    = 1'b0;
      end
   endfunction

   task automatic check_fit(lslf_rsp_type got);
      lslf_rsp_type want;
      if (fit_queue.size() == 0) begin
         report_mismatch($sformatf("unexpected fit: slope %0d intercept %0d points %0d",
                                   got.fit_slope, got.fit_intercept, got.points_used));
      end else begin
         want = fit_queue.pop_front();
         if (got.fit_slope !== want.fit_slope)
            report_mismatch($sformatf("fit %0d slope %0d, want %0d",
                                      fits_seen, got.fit_slope, want.fit_slope));
         if (got.fit_intercept !== want.fit_intercept)
            report_mismatch($sformatf("fit %0d intercept %0d, want %0d",
                                      fits_seen, got.fit_intercept, want.fit_intercept));
         if (got.points_used !== want.points_used)
            report_mismatch($sformatf("fit %0d points_used %0d, want %0d",
                                      fits_seen, got.points_used, want.points_used));
         if (got.degenerate !== want.degenerate)
            report_mismatch($sformatf("fit %0d degenerate %b, want %b",
                                      fits_seen, got.degenerate, want.degenerate));
         if (got.overflowed !== want.overflowed)
            report_mismatch($sformatf("fit %0d overflowed %b, want %b",
                                      fits_seen, got.overflowed, want.overflowed));
      end
      fits_seen++;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------------
   task automatic queue_point(int x, int y, bit last);
      lslf_req_type pt;
      pt.x_value = x[15:0];
      pt.y_value = y[15:0];
      pt.is_last = last;
      point_queue.insert(point_queue.size(), pt);
   endtask

   task automatic queue_set(int n_points, set_shape_type shape);
      int base, step, offset, slope_q, noise, x, y, k;
      base    = $urandom_range(65535);
      step    = $urandom_range(1, 300);
      offset  = $urandom_range(65535);
      offset  = offset - 32768;
      slope_q = $urandom_range(2000);
      slope_q = slope_q - 1000;
      for (k = 0; k < n_points; k++) begin
         noise = $urandom_range(40);
         case (shape)
            SET_RAMP: begin
               x = base + k * step;
               y = offset + (slope_q * k) / 4 + noise - 20;
            end
            SET_SAME_X: begin
               x = base;
               y = $urandom_range(65535);
            end
            SET_NARROW: begin
               x = $urandom_range(3);
               x = x + base;
               y = noise * 5 - 100;
            end
            default: begin
               x = $urandom_range(65535);
               y = $urandom_range(65535);
            end
         endcase
         queue_point(x, y, k == n_points - 1);
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: presents the next queued point, holds it while stalled, and
   // hands each accepted transaction to the predictor.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            accumulate_point(req_data);
         if (!req_valid || !req_stall) begin
            if (point_queue.size() != 0 && !sender_rests()) begin
               req_data  <= point_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each accepted fit transaction and drives result stalls.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_fit(rsp_data);
         rsp_stall <= hold_off || receiver_rests();
      end
   end

   // ------------------------------------------------------------------------
   // Long hold-off once the random sets are flowing: the pending fit cannot
   // leave, so after the next fit the input stays stalled as points wait.
   // ------------------------------------------------------------------------
   initial begin
      wait (fits_seen >= 8);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // phase clock and watchdog on transaction silence
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int random_points;
      int n_points;
      int pick;
      random_points = 0;

      // single points: nothing to divide by
      queue_point(0, 0, 1'b1);
      queue_point(65535, -32768, 1'b1);
      // several points sharing one x
      queue_point(1234, 100, 1'b0);
      queue_point(1234, -5, 1'b0);
      queue_point(1234, 32767, 1'b1);
      // full span of both fields
      queue_point(0, -32768, 1'b0);
      queue_point(65535, 32767, 1'b1);
      // steep line far out in x: intercept clamps high, then low
      queue_point(65534, 32767, 1'b0);
      queue_point(65535, -32768, 1'b1);
      queue_point(65534, -32768, 1'b0);
      queue_point(65535, 32767, 1'b1);
      // ordinary set
      queue_point(10, 256, 1'b0);
      queue_point(20, 512, 1'b0);
      queue_point(30, 700, 1'b0);
      queue_point(40, 1100, 1'b1);
      // mid-scale x and y of -1
      queue_point(32768, -1, 1'b0);
      queue_point(1, 1, 1'b1);

      // random sets, mostly short
      while (random_points < RANDOM_POINTS) begin
         pick = $urandom_range(99);
         if (pick < 8)
            n_points = 1;
         else if (pick < 13)
            n_points = $urandom_range(100, 400);
         else
            n_points = $urandom_range(2, 24);
         queue_set(n_points, set_shape_type'($urandom_range(3)));
         random_points += n_points;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      wait (point_queue.size() == 0 && !req_valid);
      wait (fit_queue.size() == 0);
      // catch any stray result after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fit_queue.size() != 0)
         report_mismatch($sformatf("%0d fits never arrived", fit_queue.size()));
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
